@@ design/qcpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// qcpwm_pkg
// Shared types and constants for the quadrature counter with PWM drive.
// ----------------------------------------------------------------------------
package qcpwm_pkg;

  // function codes carried by an input beat
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // host word that clears the position instead of setting the duty
  localparam logic [31:0] CLEAR_WORD   = 32'd59595959;
  localparam logic [31:0] PERIOD_RESET = 32'd1000000;
  localparam logic [31:0] DUTY_RESET   = 32'd500000;

  // payload of one input beat
  typedef struct packed {
    logic               func;
    logic               chan_a;
    logic               chan_b;
    logic signed [31:0] write_data;
  } in_beat_t;

  // payload of one result beat
  typedef struct packed {
    logic signed [31:0] position;
    logic               pwm_level;
  } out_beat_t;

endpackage

@@ design/qcpwm_if.sv @@
// ----------------------------------------------------------------------------
// qcpwm_if
// Valid/ready channels for the input beats and the result beats.
// ----------------------------------------------------------------------------
interface qcpwm_in_if
  import qcpwm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qcpwm_out_if
  import qcpwm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/quadrature_counter_with_pwm_drive_top.sv @@
// ----------------------------------------------------------------------------
// quadrature_counter_with_pwm_drive_top
// x4 quadrature position counter and PWM generator driven by tick/write beats.
// ----------------------------------------------------------------------------
// The result of an accepted input beat is registered and offered in the next cycle.
// Throughput: one beat per cycle; the single result register is refilled in
//   the cycle it is taken, so input ready only drops while a result stalls.
// Reset (rst_n low, synchronous): position, held levels and period counter
//   go to zero, both duties to 500000, the period to 1000000, no result held.
module quadrature_counter_with_pwm_drive_top
  import qcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  qcpwm_in_if.sink           in_chan,
  qcpwm_out_if.source        out_chan,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  // state
  logic [31:0] period_r;
  logic [31:0] pos_r, pos_nxt;
  logic        held_a_r, held_a_nxt;
  logic        held_b_r, held_b_nxt;
  logic [31:0] pcnt_r, pcnt_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [31:0] act_r, act_nxt;
  logic        out_valid_r;
  out_beat_t   out_data_r, out_data_nxt;

  logic        accept;
  logic [31:0] eff_period;
  logic [31:0] pcnt_start;
  logic        a_moved, b_moved;
  logic        level;

  // take a beat whenever the result slot is free or is being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // zero period behaves as a period of one tick
  assign eff_period = (period_r == '0) ? 32'd1 : period_r;
  // wrap a counter left beyond a lowered period
  assign pcnt_start = (pcnt_r >= eff_period) ? '0 : pcnt_r;

  assign a_moved = in_chan.data.chan_a != held_a_r;
  assign b_moved = in_chan.data.chan_b != held_b_r;

  // compute the next state and the result of the offered beat
  always_comb begin
    pos_nxt    = pos_r;
    held_a_nxt = held_a_r;
    held_b_nxt = held_b_r;
    pcnt_nxt   = pcnt_r;
    pend_nxt   = pend_r;
    act_nxt    = act_r;
    level      = 1'b0;
    unique case (in_chan.data.func)
      FUNC_WRITE: begin
        if (in_chan.data.write_data == CLEAR_WORD) begin
          pos_nxt = '0;
        end else begin
          pend_nxt = in_chan.data.write_data;
        end
        level = pcnt_r < act_r;
      end
      FUNC_TICK: begin
        // count edges; a change on both channels cancels out
        if (a_moved && !b_moved) begin
          pos_nxt = (in_chan.data.chan_a == in_chan.data.chan_b) ? pos_r - 32'd1
                                                                 : pos_r + 32'd1;
        end else if (b_moved && !a_moved) begin
          pos_nxt = (in_chan.data.chan_b == held_a_r) ? pos_r + 32'd1
                                                      : pos_r - 32'd1;
        end
        held_a_nxt = in_chan.data.chan_a;
        held_b_nxt = in_chan.data.chan_b;
        // latch the pending duty at period start
        if (pcnt_start == '0) begin
          act_nxt = pend_r;
        end
        level    = pcnt_start < act_nxt;
        pcnt_nxt = (pcnt_start >= eff_period - 32'd1) ? '0 : pcnt_start + 32'd1;
      end
      default: ;
    endcase
    out_data_nxt.position  = pos_nxt;
    out_data_nxt.pwm_level = level;
  end

  // advance the state on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      held_a_r <= 1'b0;
      held_b_r <= 1'b0;
      pcnt_r   <= '0;
      pend_r   <= DUTY_RESET;
      act_r    <= DUTY_RESET;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      held_a_r <= held_a_nxt;
      held_b_r <= held_b_nxt;
      pcnt_r   <= pcnt_nxt;
      pend_r   <= pend_nxt;
      act_r    <= act_nxt;
    end
  end

  // hold the period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // a tick leaves the period counter inside the period
  a_pcnt_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.data.func == FUNC_TICK && !cfg_we)
      |=> (pcnt_r < eff_period))
    else $error("period counter left the period after a tick");

  // the clear word zeroes the position and the reported result
  a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.data.func == FUNC_WRITE && in_chan.data.write_data == CLEAR_WORD)
      |=> (pos_r == '0 && out_data_r.position == '0))
    else $error("clear word did not clear the position");

  // a simultaneous change on both channels keeps the position
  a_both_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.data.func == FUNC_TICK && a_moved && b_moved)
      |=> (pos_r == $past(pos_r)))
    else $error("double edge changed the position");

  // a host write does not advance time
  a_write_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.data.func == FUNC_WRITE)
      |=> (pcnt_r == $past(pcnt_r) && act_r == $past(act_r)))
    else $error("host write moved the PWM timing");

  // input stalls only while a result waits
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_valid_r && !out_chan.ready))
    else $error("input stalled without a pending result");

endmodule

@@ sim/tb_quadrature_counter_with_pwm_drive_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_counter_with_pwm_drive_top
// Self-checking bench for the quadrature counter with PWM drive. Tick and
// host-write beats go in through a valid/ready channel with random gaps.
// Each accepted beat is run through a tracker of position and PWM state.
// Every result beat is compared with the oldest predicted reading. The
// period register is reprogrammed between phases, only once the block is idle.
// ----------------------------------------------------------------------------
module tb_quadrature_counter_with_pwm_drive_top;
  import qcpwm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 115;

  // Track encoder position and PWM phase, and queue the predicted readings.
  class position_pwm_tracker;
    logic [31:0] period_len;
    logic [31:0] position;
    logic [31:0] period_count;
    logic [31:0] pending_duty;
    logic [31:0] active_duty;
    logic        held_a;
    logic        held_b;
    out_beat_t   predicted_readings[$];
    int          mismatches;

    function new();
      period_len   = PERIOD_RESET;
      position     = '0;
      period_count = '0;
      pending_duty = DUTY_RESET;
      active_duty  = DUTY_RESET;
      held_a       = 1'b0;
      held_b       = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_period(logic [31:0] len);
      period_len = len;
    endfunction

    function int outstanding();
      return predicted_readings.size();
    endfunction

    // Advance the state by one accepted input beat and queue its reading.
    function void note_beat(in_beat_t beat);
      out_beat_t   want;
      logic [31:0] span;
      logic        a_moved;
      logic        b_moved;
      if (beat.func == FUNC_WRITE) begin
        if ($unsigned(beat.write_data) == CLEAR_WORD) begin
          position = '0;
        end else begin
          pending_duty = beat.write_data;
        end
        want.pwm_level = (period_count < active_duty);
      end else begin
        span    = (period_len == '0) ? 32'd1 : period_len;
        a_moved = (beat.chan_a != held_a);
        b_moved = (beat.chan_b != held_b);
        // a single-channel edge counts; a double edge cancels out
        if (a_moved && !b_moved) begin
          position = (beat.chan_a == beat.chan_b) ? position - 32'd1 : position + 32'd1;
        end else if (b_moved && !a_moved) begin
          position = (beat.chan_b == held_a) ? position + 32'd1 : position - 32'd1;
        end
        held_a = beat.chan_a;
        held_b = beat.chan_b;
        // wrap a counter left beyond a shortened period
        if (period_count >= span) begin
          period_count = '0;
        end
        if (period_count == '0) begin
          active_duty = pending_duty;
        end
        want.pwm_level = (period_count < active_duty);
        if (period_count >= span - 32'd1) begin
          period_count = '0;
        end else begin
          period_count = period_count + 32'd1;
        end
      end
      want.position = position;
      predicted_readings.push_back(want);
    endfunction

    // Compare one result beat with the oldest predicted reading.
    function void check_reading(out_beat_t got);
      out_beat_t want;
      if (predicted_readings.size() == 0) begin
        $display("%0t: unexpected result beat, position %0d level %0b",
                 $time, got.position, got.pwm_level);
        mismatches++;
        return;
      end
      want = predicted_readings.pop_front();
      if (got.position !== want.position) begin
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, got.position);
        mismatches++;
      end
      if (got.pwm_level !== want.pwm_level) begin
        $display("%0t: pwm_level mismatch, expected %0b, actual %0b",
                 $time, want.pwm_level, got.pwm_level);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        steady;
  logic        enc_a;
  logic        enc_b;
  logic        walk_fwd;
  int          stall_left = 0;
  int          cycles = 0;

  logic [31:0] phase_periods [10] = '{32'd5, 32'd1, 32'd16, 32'd0, 32'd2, 32'd64,
                                      32'hFFFF_FFFF, 32'd7, 32'd1000000, 32'd3};

  position_pwm_tracker tracker;

  qcpwm_in_if  in_chan ();
  qcpwm_out_if out_chan ();

  quadrature_counter_with_pwm_drive_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result channel in short random bursts.
  always @(negedge clk) begin
    if (!rst_n || steady) begin
      out_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Check every result beat taken.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tracker.check_reading(out_chan.data);
    end
  end

  function automatic in_beat_t tick_of(logic a, logic b);
    in_beat_t beat;
    beat.func       = FUNC_TICK;
    beat.chan_a     = a;
    beat.chan_b     = b;
    beat.write_data = $urandom;
    return beat;
  endfunction

  function automatic in_beat_t word_of(logic [31:0] word);
    in_beat_t beat;
    beat.func       = FUNC_WRITE;
    beat.chan_a     = 1'($urandom);
    beat.chan_b     = 1'($urandom);
    beat.write_data = word;
    return beat;
  endfunction

  // Offer one beat, sometimes after a random gap; leave valid high on return.
  task automatic send_beat(in_beat_t beat);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= beat;
    do @(posedge clk); while (!in_chan.ready);
    tracker.note_beat(beat);
    @(negedge clk);
  endtask

  // Hold the input off until every predicted reading has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_period(logic [31:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_period(len);
  endtask

  // One phase of random beats, mostly a legal quadrature walk.
  task automatic run_phase(logic [31:0] len, int beats);
    logic [31:0] span;
    logic [31:0] word;
    int          pick;
    program_period(len);
    span = (len == '0) ? 32'd1 : len;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        if ($urandom_range(0, 19) == 0) begin
          walk_fwd = !walk_fwd;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          if ((enc_a == enc_b) == walk_fwd) enc_a = !enc_a;
          else enc_b = !enc_b;
        end else if (pick == 7) begin
          enc_a = !enc_a;
          enc_b = !enc_b;
        end else if (pick == 8) begin
          enc_a = 1'($urandom);
          enc_b = 1'($urandom);
        end
        send_beat(tick_of(enc_a, enc_b));
      end else begin
        case ($urandom_range(0, 9))
          0: word = CLEAR_WORD;
          1: word = $urandom;
          2: word = 32'h8000_0000 | $urandom;
          default: begin
            word = (span < 32'd64) ? $urandom_range(0, span + 1) : $urandom_range(0, 200);
          end
        endcase
        send_beat(word_of(word));
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    steady         = 1'b0;
    enc_a          = 1'b0;
    enc_b          = 1'b0;
    walk_fwd       = 1'b1;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    tracker        = new();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk all four single-channel edges forward, two of them back, then a double edge.
    send_beat(tick_of(1'b0, 1'b0));
    send_beat(tick_of(1'b1, 1'b0));
    send_beat(tick_of(1'b1, 1'b1));
    send_beat(tick_of(1'b0, 1'b1));
    send_beat(tick_of(1'b0, 1'b0));
    send_beat(tick_of(1'b0, 1'b1));
    send_beat(tick_of(1'b1, 1'b1));
    send_beat(tick_of(1'b0, 1'b0));

    // Host words: clear, zero, negative and extreme duties.
    send_beat(word_of(CLEAR_WORD));
    send_beat(word_of(32'd0));
    send_beat(word_of(32'hFFFF_FFFF));
    send_beat(word_of(32'h8000_0000));
    send_beat(word_of(32'h7FFF_FFFF));
    send_beat(word_of(32'd2));
    send_beat(tick_of(1'b0, 1'b0));
    send_beat(tick_of(1'b0, 1'b0));

    // Shorten the period below the running counter.
    program_period(32'd3);
    send_beat(tick_of(1'b1, 1'b0));
    send_beat(tick_of(1'b1, 1'b1));
    send_beat(tick_of(1'b1, 1'b1));

    // Zero period behaves as one tick per period.
    program_period(32'd0);
    send_beat(word_of(32'hFFFF_FFFF));
    send_beat(tick_of(1'b0, 1'b1));
    send_beat(word_of(32'd0));
    send_beat(tick_of(1'b0, 1'b0));

    program_period(32'hFFFF_FFFF);
    send_beat(tick_of(1'b1, 1'b0));
    send_beat(tick_of(1'b0, 1'b1));
    enc_a = 1'b0;
    enc_b = 1'b1;

    // Random phases over a spread of periods; the last one runs without gaps.
    foreach (phase_periods[i]) begin
      if (i == 9) begin
        steady = 1'b1;
      end
      run_phase(phase_periods[i], PHASE_BEATS);
    end

    drain();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
